@@ hw/rtl/osd_pkg.sv @@
package osd_pkg;

  // Input item kinds carried in s_tuser.
  localparam logic [1:0] FUNC_LINE  = 2'd0;
  localparam logic [1:0] FUNC_FRAME = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [3:0] CFG_HEADER_TOP   = 4'd0;
  localparam logic [3:0] CFG_STATUS_TOP   = 4'd1;
  localparam logic [3:0] CFG_TIME_TOP     = 4'd2;
  localparam logic [3:0] CFG_DATE_TOP     = 4'd3;
  localparam logic [3:0] CFG_HEADER_DELAY = 4'd4;
  localparam logic [3:0] CFG_STATUS_DELAY = 4'd5;
  localparam logic [3:0] CFG_TIME_DELAY   = 4'd6;
  localparam logic [3:0] CFG_DATE_DELAY   = 4'd7;

  localparam int NUM_WIN = 4;

  // Register file contents: window top lines and timer preloads, in window order.
  typedef struct packed {
    logic [NUM_WIN-1:0][7:0] top_line;
    logic [NUM_WIN-1:0][7:0] start_delay;
  } osd_cfg_t;

  localparam osd_cfg_t CFG_RESET = '{
    top_line:    {8'd241, 8'd231, 8'd221, 8'd41},
    start_delay: {8'd185, 8'd175, 8'd172, 8'd135}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_EMIT
  } osd_state_t;

  // Font geometry.
  localparam int         FONT_ROWS    = 7;
  localparam int         LETTER_COUNT = 27;
  localparam int         DIGIT_COUNT  = 14;
  localparam logic [6:0] LETTER_FIRST = 7'd64;
  localparam logic [6:0] LETTER_END   = 7'd91;
  localparam logic [6:0] DIGIT_FIRST  = 7'd45;
  localparam logic [6:0] DIGIT_END    = 7'd59;
  localparam logic [7:0] BLANK_BYTE   = 8'hFF;

  localparam logic [7:0] LETTER_ROM [0:188] = '{
    8'd255,8'd231,8'd131,8'd195,8'd135,8'd129,8'd129,8'd195,8'd189,8'd131,8'd129,8'd189,8'd191,
    8'd125,8'd125,8'd195,8'd131,8'd195,8'd131,8'd195,8'd131,8'd189,8'd189,8'd125,8'd125,8'd125,
    8'd1,
    8'd255,8'd219,8'd189,8'd189,8'd187,8'd191,8'd191,8'd189,8'd189,8'd239,8'd247,8'd187,8'd191,
    8'd57,8'd61,8'd189,8'd189,8'd189,8'd189,8'd189,8'd239,8'd189,8'd189,8'd125,8'd187,8'd187,
    8'd251,
    8'd255,8'd189,8'd189,8'd191,8'd189,8'd191,8'd191,8'd191,8'd189,8'd239,8'd247,8'd183,8'd191,
    8'd85,8'd93,8'd189,8'd189,8'd189,8'd189,8'd191,8'd239,8'd189,8'd189,8'd109,8'd215,8'd215,
    8'd247,
    8'd255,8'd189,8'd131,8'd191,8'd189,8'd131,8'd131,8'd177,8'd129,8'd239,8'd247,8'd143,8'd191,
    8'd109,8'd109,8'd189,8'd131,8'd189,8'd131,8'd195,8'd239,8'd189,8'd219,8'd109,8'd239,8'd239,
    8'd239,
    8'd255,8'd129,8'd189,8'd191,8'd189,8'd191,8'd191,8'd189,8'd189,8'd239,8'd247,8'd183,8'd191,
    8'd125,8'd117,8'd189,8'd191,8'd179,8'd183,8'd253,8'd239,8'd189,8'd219,8'd109,8'd215,8'd239,
    8'd223,
    8'd255,8'd189,8'd189,8'd189,8'd187,8'd191,8'd191,8'd189,8'd189,8'd239,8'd183,8'd187,8'd129,
    8'd125,8'd121,8'd189,8'd191,8'd185,8'd187,8'd189,8'd239,8'd189,8'd219,8'd147,8'd187,8'd239,
    8'd191,
    8'd255,8'd189,8'd131,8'd195,8'd135,8'd129,8'd191,8'd195,8'd189,8'd131,8'd207,8'd189,8'd129,
    8'd125,8'd125,8'd195,8'd191,8'd205,8'd189,8'd195,8'd239,8'd195,8'd231,8'd147,8'd125,8'd239,
    8'd1
  };

  localparam logic [7:0] DIGIT_ROM [0:97] = '{
    8'd255,8'd255,8'd207,8'd131,8'd239,8'd131,8'd131,8'd227,8'd1,8'd131,8'd1,8'd131,8'd131,8'd255,
    8'd255,8'd255,8'd187,8'd125,8'd207,8'd125,8'd125,8'd219,8'd127,8'd127,8'd253,8'd125,8'd125,
    8'd239,
    8'd255,8'd255,8'd187,8'd125,8'd239,8'd253,8'd253,8'd187,8'd127,8'd127,8'd251,8'd125,8'd125,
    8'd255,
    8'd131,8'd255,8'd207,8'd125,8'd239,8'd243,8'd227,8'd123,8'd131,8'd3,8'd247,8'd131,8'd129,
    8'd255,
    8'd255,8'd255,8'd255,8'd125,8'd239,8'd207,8'd253,8'd1,8'd253,8'd125,8'd239,8'd125,8'd251,
    8'd255,
    8'd255,8'd231,8'd255,8'd125,8'd239,8'd191,8'd125,8'd251,8'd125,8'd125,8'd239,8'd125,8'd247,
    8'd239,
    8'd255,8'd231,8'd255,8'd131,8'd199,8'd1,8'd131,8'd251,8'd131,8'd131,8'd239,8'd131,8'd207,
    8'd255
  };

  // Text shown in the slots until they are first written.
  localparam int INIT_SLOTS = 47;
  localparam logic [6:0] INIT_TEXT [0:INIT_SLOTS-1] = '{
    7'd78,7'd52,7'd84,7'd88,7'd73,7'd64,7'd66,7'd65,7'd76,7'd76,7'd79,7'd79,7'd78,
    7'd49,7'd54,7'd55,
    7'd50,7'd56,7'd57,
    7'd49,7'd52,7'd53,7'd52,7'd52,7'd54,
    7'd49,7'd50,7'd50,7'd53,7'd48,7'd52,
    7'd64,7'd51,7'd52,7'd51,7'd53,7'd46,7'd54,7'd56,
    7'd48,7'd56,7'd57,7'd49,7'd56,7'd46,7'd55,7'd53
  };

  // One drawn glyph: font ROM, font size, and either a slot index or a literal code.
  typedef struct packed {
    logic       digit;
    logic       narrow;
    logic       from_slot;
    logic [6:0] val;
  } osd_item_t;

  localparam int NUM_ITEMS = 69;

  localparam osd_item_t ITEM_TAB [0:NUM_ITEMS-1] = '{
    // Header caption.
    '{1'b0,1'b0,1'b1,7'd0},  '{1'b1,1'b0,1'b1,7'd1},  '{1'b0,1'b0,1'b1,7'd2},
    '{1'b0,1'b0,1'b1,7'd3},  '{1'b0,1'b0,1'b1,7'd4},  '{1'b0,1'b0,1'b1,7'd5},
    '{1'b0,1'b0,1'b1,7'd6},  '{1'b0,1'b0,1'b1,7'd7},  '{1'b0,1'b0,1'b1,7'd8},
    '{1'b0,1'b0,1'b1,7'd9},  '{1'b0,1'b0,1'b1,7'd10}, '{1'b0,1'b0,1'b1,7'd11},
    '{1'b0,1'b0,1'b1,7'd12},
    // Speed, heading and altitude.
    '{1'b0,1'b1,1'b0,7'd83}, '{1'b1,1'b1,1'b0,7'd58}, '{1'b1,1'b1,1'b1,7'd13},
    '{1'b1,1'b1,1'b1,7'd14}, '{1'b1,1'b1,1'b1,7'd15}, '{1'b0,1'b1,1'b0,7'd64},
    '{1'b0,1'b1,1'b0,7'd72}, '{1'b1,1'b1,1'b0,7'd58}, '{1'b1,1'b1,1'b1,7'd16},
    '{1'b1,1'b1,1'b1,7'd17}, '{1'b1,1'b1,1'b1,7'd18}, '{1'b0,1'b1,1'b0,7'd64},
    '{1'b0,1'b1,1'b0,7'd65}, '{1'b1,1'b1,1'b0,7'd58},
    '{1'b1,1'b0,1'b1,7'd19}, '{1'b1,1'b0,1'b1,7'd20}, '{1'b1,1'b0,1'b1,7'd21},
    '{1'b1,1'b0,1'b1,7'd22}, '{1'b1,1'b0,1'b1,7'd23}, '{1'b1,1'b0,1'b1,7'd24},
    // Time and latitude.
    '{1'b1,1'b1,1'b1,7'd19}, '{1'b1,1'b1,1'b1,7'd20}, '{1'b1,1'b1,1'b0,7'd58},
    '{1'b1,1'b1,1'b1,7'd21}, '{1'b1,1'b1,1'b1,7'd22}, '{1'b1,1'b1,1'b0,7'd58},
    '{1'b1,1'b1,1'b1,7'd23}, '{1'b1,1'b1,1'b1,7'd24}, '{1'b0,1'b1,1'b0,7'd64},
    '{1'b0,1'b0,1'b1,7'd31}, '{1'b1,1'b0,1'b1,7'd32}, '{1'b1,1'b0,1'b1,7'd33},
    '{1'b1,1'b1,1'b0,7'd47}, '{1'b1,1'b0,1'b1,7'd34}, '{1'b1,1'b0,1'b1,7'd35},
    '{1'b1,1'b1,1'b1,7'd36}, '{1'b1,1'b0,1'b1,7'd37}, '{1'b1,1'b0,1'b1,7'd38},
    // Date and longitude.
    '{1'b1,1'b1,1'b1,7'd25}, '{1'b1,1'b1,1'b1,7'd26}, '{1'b1,1'b1,1'b0,7'd45},
    '{1'b1,1'b1,1'b1,7'd27}, '{1'b1,1'b1,1'b1,7'd28}, '{1'b1,1'b1,1'b0,7'd45},
    '{1'b1,1'b1,1'b1,7'd29}, '{1'b1,1'b1,1'b1,7'd30}, '{1'b0,1'b1,1'b0,7'd64},
    '{1'b1,1'b0,1'b1,7'd39}, '{1'b1,1'b0,1'b1,7'd40}, '{1'b1,1'b0,1'b1,7'd41},
    '{1'b1,1'b1,1'b0,7'd47}, '{1'b1,1'b0,1'b1,7'd42}, '{1'b1,1'b0,1'b1,7'd43},
    '{1'b1,1'b1,1'b1,7'd44}, '{1'b1,1'b0,1'b1,7'd45}, '{1'b1,1'b0,1'b1,7'd46}
  };

  // First and final item of each window, in window order.
  localparam logic [6:0] WIN_FIRST [0:NUM_WIN-1] = '{7'd0, 7'd13, 7'd33, 7'd51};
  localparam logic [6:0] WIN_LAST  [0:NUM_WIN-1] = '{7'd12, 7'd32, 7'd50, 7'd68};

  // Power-up content of a text slot.
  function automatic logic [6:0] init_text(input logic [7:0] slot);
    logic [6:0] res;
    res = '0;
    if (slot < 8'(INIT_SLOTS)) begin
      res = INIT_TEXT[slot[5:0]];
    end
    return res;
  endfunction

  // Font row byte of one glyph; codes outside the chosen ROM read as blank.
  function automatic logic [7:0] glyph_byte(input logic digit, input logic [6:0] code,
                                            input logic [3:0] row);
    logic [7:0] idx;
    logic [7:0] res;
    idx = '0;
    res = BLANK_BYTE;
    if (row < 4'(FONT_ROWS)) begin
      if (digit) begin
        if (code >= DIGIT_FIRST && code < DIGIT_END) begin
          idx = 8'(row) * 8'(DIGIT_COUNT) + 8'(code - DIGIT_FIRST);
          res = DIGIT_ROM[idx[6:0]];
        end
      end else begin
        if (code >= LETTER_FIRST && code < LETTER_END) begin
          idx = 8'(row) * 8'(LETTER_COUNT) + 8'(code - LETTER_FIRST);
          res = LETTER_ROM[idx];
        end
      end
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/osd_ram.sv @@
module osd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/osd_text_store.sv @@
module osd_text_store
  import osd_pkg::*;
#(
  parameter int TEXT_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [$clog2(TEXT_SLOTS)-1:0] wr_addr,
  input  logic [6:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(TEXT_SLOTS)-1:0] rd_addr,
  output logic [6:0]                    rd_data
);

  logic [TEXT_SLOTS-1:0] written;
  logic                  written_q;
  logic [6:0]            init_q;
  logic [6:0]            ram_q;

  osd_ram #(
    .WIDTH (7),
    .DEPTH (TEXT_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // A slot that was never written since reset shows its power-up text.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Track the slot's written flag and power-up text alongside the RAM read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      written_q <= written[rd_addr];
      init_q    <= init_text(8'(rd_addr));
    end
  end

  assign rd_data = written_q ? ram_q : init_q;

endmodule

@@ hw/rtl/osd_line_ctrl.sv @@
module osd_line_ctrl
  import osd_pkg::*;
#(
  parameter int TEXT_SLOTS = 64,
  parameter int GLYPH_ROWS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  osd_cfg_t                      cfg,
  // Input transaction.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  // Text store read port.
  output logic                          rd_en,
  output logic [$clog2(TEXT_SLOTS)-1:0] rd_addr,
  input  logic [6:0]                    rd_data,
  // Result transaction.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    pixel_byte,
  output logic                          narrow_pixels,
  output logic [7:0]                    start_delay,
  output logic                          overlay_active,
  output logic                          out_last
);

  localparam int SLOT_AW = $clog2(TEXT_SLOTS);
  localparam int ROW_W   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  osd_state_t       state, state_next;
  logic [7:0]       line_count, line_count_next;
  logic [ROW_W-1:0] row, row_next;
  logic [6:0]       item_idx, item_idx_next;
  logic [6:0]       item_last, item_last_next;
  logic             blank, blank_next;
  logic [7:0]       delay, delay_next;

  logic             out_valid_next;
  logic [7:0]       pixel_byte_next;
  logic             narrow_pixels_next;
  logic [7:0]       start_delay_next;
  logic             overlay_active_next;
  logic             out_last_next;

  osd_item_t        item;
  logic [6:0]       code;
  logic             out_free;
  logic             found;
  logic [7:0]       line_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      line_count <= line_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    row            <= row_next;
    item_idx       <= item_idx_next;
    item_last      <= item_last_next;
    blank          <= blank_next;
    delay          <= delay_next;
    pixel_byte     <= pixel_byte_next;
    narrow_pixels  <= narrow_pixels_next;
    start_delay    <= start_delay_next;
    overlay_active <= overlay_active_next;
    out_last       <= out_last_next;
  end

  // Current glyph and its character code, from the text store or the table.
  assign item     = ITEM_TAB[item_idx];
  assign code     = item.from_slot ? rd_data : item.val;
  assign rd_addr  = SLOT_AW'(item.val);
  assign out_free = !out_valid || out_ready;

  // Sequencer: line setup, then one text store read and one result per glyph, or a single blank result.
  always_comb begin
    state_next          = state;
    line_count_next     = line_count;
    row_next            = row;
    item_idx_next       = item_idx;
    item_last_next      = item_last;
    blank_next          = blank;
    delay_next          = delay;
    out_valid_next      = out_valid && !out_ready;
    pixel_byte_next     = pixel_byte;
    narrow_pixels_next  = narrow_pixels;
    start_delay_next    = start_delay;
    overlay_active_next = overlay_active;
    out_last_next       = out_last;
    in_ready            = 1'b0;
    rd_en               = 1'b0;
    found               = 1'b0;
    line_off            = '0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_LINE) begin
            line_count_next = line_count + 8'd1;
            state_next      = ST_CALC;
          end else if (func == FUNC_FRAME) begin
            line_count_next = '0;
          end
        end
      end

      ST_CALC: begin
        // Later window thresholds override earlier ones.
        delay_next = cfg.start_delay[0];
        for (int w = 1; w < NUM_WIN; w++) begin
          if (line_count >= cfg.top_line[w]) begin
            delay_next = cfg.start_delay[w];
          end
        end
        // The first window that holds this line is drawn.
        blank_next = 1'b1;
        for (int w = 0; w < NUM_WIN; w++) begin
          line_off = line_count - cfg.top_line[w];
          if (!found && line_off < 8'(GLYPH_ROWS)) begin
            found          = 1'b1;
            blank_next     = 1'b0;
            row_next       = ROW_W'(line_off);
            item_idx_next  = WIN_FIRST[w];
            item_last_next = WIN_LAST[w];
          end
        end
        state_next = found ? ST_READ : ST_EMIT;
      end

      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_next      = 1'b1;
          start_delay_next    = delay;
          pixel_byte_next     = blank ? BLANK_BYTE : glyph_byte(item.digit, code, 4'(row));
          narrow_pixels_next  = !blank && item.narrow;
          overlay_active_next = !blank;
          out_last_next       = blank || (item_idx == item_last);
          if (blank || item_idx == item_last) begin
            state_next = ST_IDLE;
          end else begin
            item_idx_next = item_idx + 7'd1;
            state_next    = ST_READ;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/video_text_overlay_line_generator.sv @@
// On-screen-display text line generator. Each transaction on the slave stream
// carries a kind in s_tuser: a line start advances the 8-bit line counter and
// produces the line's timer preload together with, when the line falls in one of
// the four text windows, one font row byte per glyph of that window (13, 20, 18
// or 18 bytes, tlast on the final one); a line with no text produces a single
// blank byte with overlay_active low. A frame start clears the line counter, and
// a write loads one text slot; neither produces output. The text slots live in
// a synchronous RAM with a registered read, so every glyph takes a read state
// and then an output state, which waits while the master side stalls. The
// block takes one input transaction at a time. No clearing pass is needed
// after reset; unwritten slots show the built-in text. The user must make
// configuration writes through the cfg port only while no line is in progress;
// the block itself does not enforce this.
module video_text_overlay_line_generator
  import osd_pkg::*;
#(
  parameter int TEXT_SLOTS = 64,
  parameter int GLYPH_ROWS = 7
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] slot_index, [12:6] char_code, [15:13] zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] pixel_byte, [15:8] start_delay
  output logic [1:0]  m_tuser,   // [0] narrow_pixels, [1] overlay_active
  output logic        m_tlast
);

  localparam int SLOT_AW = $clog2(TEXT_SLOTS);

  osd_cfg_t           cfg;
  logic [5:0]         slot_index;
  logic [6:0]         char_code;
  logic               wr_en;
  logic               rd_en;
  logic [SLOT_AW-1:0] rd_addr;
  logic [6:0]         rd_data;
  logic [7:0]         pixel_byte;
  logic [7:0]         start_delay;
  logic               narrow_pixels;
  logic               overlay_active;

  assign slot_index = s_tdata[5:0];
  assign char_code  = s_tdata[12:6];

  // Configuration registers; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER_TOP:   cfg.top_line[0]    <= cfg_data;
        CFG_STATUS_TOP:   cfg.top_line[1]    <= cfg_data;
        CFG_TIME_TOP:     cfg.top_line[2]    <= cfg_data;
        CFG_DATE_TOP:     cfg.top_line[3]    <= cfg_data;
        CFG_HEADER_DELAY: cfg.start_delay[0] <= cfg_data;
        CFG_STATUS_DELAY: cfg.start_delay[1] <= cfg_data;
        CFG_TIME_DELAY:   cfg.start_delay[2] <= cfg_data;
        CFG_DATE_DELAY:   cfg.start_delay[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slot writes land directly in the text store; slots past its depth are dropped.
  assign wr_en = s_tvalid && s_tready && (s_tuser == FUNC_WRITE) &&
                 (9'(slot_index) < 9'(TEXT_SLOTS));

  osd_text_store #(
    .TEXT_SLOTS (TEXT_SLOTS)
  ) u_text_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (SLOT_AW'(slot_index)),
    .wr_data (char_code),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  osd_line_ctrl #(
    .TEXT_SLOTS (TEXT_SLOTS),
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_line_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .func           (s_tuser),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .pixel_byte     (pixel_byte),
    .narrow_pixels  (narrow_pixels),
    .start_delay    (start_delay),
    .overlay_active (overlay_active),
    .out_last       (m_tlast)
  );

  assign m_tdata = {start_delay, pixel_byte};
  assign m_tuser = {overlay_active, narrow_pixels};

endmodule
